// ===== src/weighted_union_find_assert.svh =====
// ----------------------------------------------------------------------------
// weighted_union_find_assert.svh
// Assertion macros shared by the disjoint-set block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_UNION_FIND_ASSERT_SVH
`define WEIGHTED_UNION_FIND_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WUF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WUF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wuf_pkg.sv =====
// ----------------------------------------------------------------------------
// wuf_pkg
// Types and constants of the weighted union-find block.
// ----------------------------------------------------------------------------
`default_nettype none

package wuf_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int ELEM_W       = 10;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int SIZE_W       = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_ELEMENTS - 1);
  localparam logic [SIZE_W:0]  SIZE_LIMIT = (SIZE_W + 1)'(NUM_ELEMENTS);

  typedef enum logic {
    CMD_CONNECT = 1'b0,
    CMD_QUERY   = 1'b1
  } wuf_cmd_t;

  // One table entry: the parent link and the tree size of an element.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  parent;
  } wuf_entry_t;

  // Write request to the table memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    wuf_entry_t       data;
  } wuf_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_GROW,
    ST_DONE
  } wuf_state_t;

endpackage

`default_nettype wire

// ===== src/wuf_ram.sv =====
// ----------------------------------------------------------------------------
// wuf_ram
// Table memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wuf_ram (
  input  wire                      clk,
  input  wire wuf_pkg::wuf_wr_t    wr,
  input  wire [wuf_pkg::IDX_W-1:0] rd_addr,
  output wuf_pkg::wuf_entry_t      rd_data
);

  wuf_pkg::wuf_entry_t mem [wuf_pkg::NUM_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/weighted_union_find.sv =====
// ----------------------------------------------------------------------------
// weighted_union_find
// Weighted quick-union disjoint-set table with stream ports.
// ----------------------------------------------------------------------------
// Each transfer on the input names a command (connect or query) and two
// element indices, and produces exactly one result transfer. After reset the
// block runs a clearing pass over all 1024 entries, one table entry per cycle, with
// s_axis_tready low; from then on every element is its own root with size 1.
// Commands are handled one at a time. Each item is accepted in idle, walks
// from element a to its root and then from element b to its root and, for
// a connect that merges, passes the link and grow states before done. All
// reads go through the single read port of the table memory, one link per
// cycle, so the root walks take most of an item's time. Union by size
// keeps every tree at most 10 links deep. A finished result sits in an
// output register, and the next command is accepted while that result
// waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_union_find_assert.svh"

module weighted_union_find (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [23:0] s_axis_tdata,   // [9:0] elem_a, [19:10] elem_b, [23:20] zero
  input  wire        s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] same_set, [1] merged, [7:2] zero
);

  localparam int IW = wuf_pkg::IDX_W;
  localparam int SW = wuf_pkg::SIZE_W;
  localparam int EW = wuf_pkg::ELEM_W;

  wuf_pkg::wuf_state_t state, state_next;

  logic [IW-1:0] clr_cnt;
  logic          cmd_q;
  logic [IW-1:0] elem_b_q;
  logic [IW-1:0] cur;
  logic [IW-1:0] root_a;
  logic [SW-1:0] size_a;
  logic [IW-1:0] root_b;
  logic [SW-1:0] size_b;
  logic          same_q;
  logic          merged_q;
  logic          same_out;
  logic          merged_out;

  wuf_pkg::wuf_wr_t    wr;
  logic [IW-1:0]       rd_addr;
  wuf_pkg::wuf_entry_t rd_data;

  logic [EW-1:0] in_a;
  logic [EW-1:0] in_b;
  logic          in_ok;
  logic          in_fire;
  logic          root_hit;
  logic          a_small;
  logic [IW-1:0] child;
  logic [IW-1:0] keeper;
  logic [SW-1:0] child_size;
  logic [SW:0]   size_sum;
  logic          out_free;

  assign in_a    = s_axis_tdata[EW-1:0];
  assign in_b    = s_axis_tdata[2*EW-1:EW];
  assign in_ok   = (32'(in_a) < wuf_pkg::NUM_ELEMENTS) &&
                   (32'(in_b) < wuf_pkg::NUM_ELEMENTS);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // The entry in rd_data belongs to cur; a self link marks a root.
  assign root_hit = (rd_data.parent == cur);

  // The smaller tree goes under the other root; on a tie b goes under a.
  assign a_small    = (size_a < size_b);
  assign child      = a_small ? root_a : root_b;
  assign keeper     = a_small ? root_b : root_a;
  assign child_size = a_small ? size_a : size_b;
  assign size_sum   = {1'b0, size_a} + {1'b0, size_b};

  assign out_free = !m_axis_tvalid || m_axis_tready;

  wuf_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      wuf_pkg::ST_CLEAR: begin
        if (clr_cnt == wuf_pkg::LAST_IDX) state_next = wuf_pkg::ST_IDLE;
      end
      wuf_pkg::ST_IDLE: begin
        if (in_fire) state_next = in_ok ? wuf_pkg::ST_WALK_A : wuf_pkg::ST_DONE;
      end
      wuf_pkg::ST_WALK_A: begin
        if (root_hit) state_next = wuf_pkg::ST_WALK_B;
      end
      wuf_pkg::ST_WALK_B: begin
        if (root_hit) begin
          if (cmd_q == wuf_pkg::CMD_CONNECT && cur != root_a) begin
            state_next = wuf_pkg::ST_LINK;
          end else begin
            state_next = wuf_pkg::ST_DONE;
          end
        end
      end
      wuf_pkg::ST_LINK: state_next = wuf_pkg::ST_GROW;
      wuf_pkg::ST_GROW: state_next = wuf_pkg::ST_DONE;
      wuf_pkg::ST_DONE: begin
        if (out_free) state_next = wuf_pkg::ST_IDLE;
      end
      default: state_next = wuf_pkg::ST_CLEAR;
    endcase
  end

  // Memory requests and input ready.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_addr       = rd_data.parent;
    wr            = '0;
    unique case (state)
      wuf_pkg::ST_CLEAR: begin
        wr.en          = 1'b1;
        wr.addr        = clr_cnt;
        wr.data.parent = clr_cnt;
        wr.data.size   = SW'(1);
      end
      wuf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_addr       = IW'(in_a);
      end
      wuf_pkg::ST_WALK_A: begin
        rd_addr = root_hit ? elem_b_q : rd_data.parent;
      end
      wuf_pkg::ST_WALK_B: begin
        rd_addr = rd_data.parent;
      end
      wuf_pkg::ST_LINK: begin
        wr.en          = 1'b1;
        wr.addr        = child;
        wr.data.parent = keeper;
        wr.data.size   = child_size;
      end
      wuf_pkg::ST_GROW: begin
        wr.en          = 1'b1;
        wr.addr        = keeper;
        wr.data.parent = keeper;
        wr.data.size   = size_sum[SW-1:0];
      end
      wuf_pkg::ST_DONE: begin
        rd_addr = cur;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wuf_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wuf_pkg::ST_CLEAR) clr_cnt <= clr_cnt + IW'(1);
      if (state == wuf_pkg::ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers; their values only matter from the walk states to done.
  always_ff @(posedge clk) begin
    unique case (state)
      wuf_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_q    <= s_axis_tuser;
          elem_b_q <= IW'(in_b);
          cur      <= IW'(in_a);
          same_q   <= 1'b0;
          merged_q <= 1'b0;
        end
      end
      wuf_pkg::ST_WALK_A: begin
        if (root_hit) begin
          root_a <= cur;
          size_a <= rd_data.size;
          cur    <= elem_b_q;
        end else begin
          cur <= rd_data.parent;
        end
      end
      wuf_pkg::ST_WALK_B: begin
        if (root_hit) begin
          root_b <= cur;
          size_b <= rd_data.size;
          same_q <= (cur == root_a);
        end else begin
          cur <= rd_data.parent;
        end
      end
      wuf_pkg::ST_GROW: begin
        merged_q <= 1'b1;
      end
      wuf_pkg::ST_DONE: begin
        if (out_free) begin
          same_out   <= same_q;
          merged_out <= merged_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {6'b0, merged_out, same_out};

  // A merge only links two distinct roots.
  `WUF_ASSERT_IMP(a_link_distinct, clk, rst, state == wuf_pkg::ST_LINK, root_a != root_b, "link of one root to itself")
  // The merged tree never holds more elements than the table.
  `WUF_ASSERT_IMP(a_size_bound, clk, rst, state == wuf_pkg::ST_GROW, size_sum <= wuf_pkg::SIZE_LIMIT, "tree size overflow")
  // A result never reports both an existing join and a fresh merge.
  `WUF_ASSERT_IMP(a_result_code, clk, rst, m_axis_tvalid, !(same_out && merged_out), "merged while already joined")
  // The clearing pass ends in idle and no command is taken before it does.
  `WUF_ASSERT_NEXT(a_clear_end, clk, rst, state == wuf_pkg::ST_CLEAR && clr_cnt == wuf_pkg::LAST_IDX, state == wuf_pkg::ST_IDLE && !m_axis_tvalid, "clearing pass did not end cleanly")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted union-find block.
// ----------------------------------------------------------------------------
// A driver pushes connect and query commands over the input stream. A monitor
// keeps its own copy of the disjoint-set forest and computes the same_set and
// merged flags for every accepted command. It then compares each returned
// result with the oldest pending prediction. The command mix starts with a
// handful of hand-picked cases. It then builds balanced trees, pair by pair,
// so the root walks get deep, with noise mixed in. A uniform random phase
// follows. Both stream sides idle and stall at random, with calm stretches
// in between.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // One command waiting in the driver queue. The gap is the number of idle
  // cycles the sender inserts ahead of it, and drain holds it back until
  // every outstanding result has come back.
  typedef struct {
    wuf_pkg::wuf_cmd_t          cmd;
    logic [wuf_pkg::ELEM_W-1:0] a;
    logic [wuf_pkg::ELEM_W-1:0] b;
    int unsigned                gap;
    bit                         drain;
  } uf_request_t;

  // A predicted result, tagged with the command that caused it.
  typedef struct {
    wuf_pkg::wuf_cmd_t          cmd;
    logic [wuf_pkg::ELEM_W-1:0] a;
    logic [wuf_pkg::ELEM_W-1:0] b;
    logic                       same_set;
    logic                       merged;
  } uf_outcome_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [7:0]  m_axis_tdata;

  weighted_union_find uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),     // [9:0] elem_a, [19:10] elem_b, [23:20] zero
    .s_axis_tuser  (s_tuser),     // [0] cmd
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata) // [0] same_set, [1] merged, [7:2] zero
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the forest: parent link and tree size per element.
  logic [wuf_pkg::IDX_W-1:0]  link_of   [wuf_pkg::NUM_ELEMENTS];
  logic [wuf_pkg::SIZE_W-1:0] weight_of [wuf_pkg::NUM_ELEMENTS];

  uf_request_t pending_q[$];
  uf_outcome_t outcome_q[$];

  int unsigned request_total  = 0;
  int unsigned accepted_total = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned wait_left      = 0;
  int unsigned stall_left     = 0;
  bit          drain_next     = 1'b0;
  bit          in_taken       = 1'b0;
  uf_request_t next_req;
  uf_outcome_t want;

  // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Follow parent links up to the root. The bound is never reached because
  // the links always form a forest.
  function automatic logic [wuf_pkg::IDX_W-1:0] root_of(
      input logic [wuf_pkg::IDX_W-1:0] e);
    logic [wuf_pkg::IDX_W-1:0] up;
    for (int step = 0; step < wuf_pkg::NUM_ELEMENTS; step++) begin
      up = link_of[e];
      if (up == e) break;
      e = up;
    end
    return e;
  endfunction

  // Apply one command to the shadow forest and return the flags it must
  // produce. With 1024 elements and 10-bit indices, every index is in
  // range, so the ignored-command path cannot be reached.
  function automatic uf_outcome_t apply_union_cmd(
      input wuf_pkg::wuf_cmd_t          cmd,
      input logic [wuf_pkg::ELEM_W-1:0] a,
      input logic [wuf_pkg::ELEM_W-1:0] b);
    uf_outcome_t res;
    logic [wuf_pkg::IDX_W-1:0] ra;
    logic [wuf_pkg::IDX_W-1:0] rb;
    res.cmd      = cmd;
    res.a        = a;
    res.b        = b;
    res.same_set = 1'b0;
    res.merged   = 1'b0;
    if (int'(a) < wuf_pkg::NUM_ELEMENTS && int'(b) < wuf_pkg::NUM_ELEMENTS) begin
      ra = root_of(wuf_pkg::IDX_W'(a));
      rb = root_of(wuf_pkg::IDX_W'(b));
      res.same_set = (ra == rb);
      if (cmd == wuf_pkg::CMD_CONNECT && ra != rb) begin
        // The smaller tree goes under the larger one. On a tie, b's root
        // goes under a's root.
        if (weight_of[ra] < weight_of[rb]) begin
          link_of[ra]   = rb;
          weight_of[rb] = weight_of[rb] + weight_of[ra];
        end else begin
          link_of[rb]   = ra;
          weight_of[ra] = weight_of[ra] + weight_of[rb];
        end
        res.merged = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic queue_request(input wuf_pkg::wuf_cmd_t cmd, input int unsigned a,
                               input int unsigned b);
    uf_request_t req;
    req.cmd   = cmd;
    req.a     = wuf_pkg::ELEM_W'(a);
    req.b     = wuf_pkg::ELEM_W'(b);
    // Every fourth block of 120 commands goes out back to back.
    req.gap   = (((request_total / 120) % 4) == 0) ? 0 : pause_len();
    req.drain = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(req);
    request_total++;
  endtask

  // A random command: either a query on a pair inside the upper half or a
  // random command on two indices taken from anywhere in the table.
  task automatic queue_noise();
    if ($urandom_range(0, 1))
      queue_request(wuf_pkg::CMD_QUERY, $urandom_range(512, 1023),
                    $urandom_range(512, 1023));
    else
      queue_request(wuf_pkg::wuf_cmd_t'($urandom_range(0, 1)),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // Sender: presents the next command at the falling edge. It holds the
  // current one until the transfer is seen at a rising edge.
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !in_taken)) begin
      if (wait_left > 0) begin
        wait_left--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && outcome_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        next_req = pending_q.pop_front();
        s_tdata  <= {4'b0000, next_req.b, next_req.a};
        s_tuser  <= next_req.cmd;
        s_tvalid <= 1'b1;
        if (pending_q.size() != 0) wait_left = pending_q[0].gap;
      end
    end
  end

  // Receiver: random back-pressure. In every fourth window of the cycle
  // count, no new stall is started.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (((cycle_count / 3000) % 4) != 0 && $urandom_range(0, 99) < 25)
        stall_left = pause_len();
    end
  end

  // Monitor: checks each returned result against the oldest prediction,
  // then records the command accepted at this edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      cycle_count++;
      if (m_axis_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: tdata=%02h", m_axis_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata[0] !== want.same_set || m_axis_tdata[1] !== want.merged ||
              m_axis_tdata[7:2] !== 6'b000000) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result mismatch: %s a=%0d b=%0d expected same_set=%0b ",
                        "merged=%0b, got same_set=%0b merged=%0b pad=%02h"},
                       want.cmd.name(), want.a, want.b, want.same_set, want.merged,
                       m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[7:2]);
          end
        end
      end
      if (s_tvalid && s_axis_tready) begin
        outcome_q.push_back(apply_union_cmd(wuf_pkg::wuf_cmd_t'(s_tuser),
                                            s_tdata[9:0], s_tdata[19:10]));
        accepted_total++;
      end
      in_taken <= s_tvalid && s_axis_tready;
    end
  end

  initial begin
    for (int i = 0; i < wuf_pkg::NUM_ELEMENTS; i++) begin
      link_of[i]   = wuf_pkg::IDX_W'(i);
      weight_of[i] = wuf_pkg::SIZE_W'(1);
    end

    // Hand-picked cases: the same element twice, ties, smaller-under-larger
    // in both argument orders, reconnecting joined elements, and index
    // extremes and alternating bit patterns.
    queue_request(wuf_pkg::CMD_QUERY,   0,     0);
    queue_request(wuf_pkg::CMD_CONNECT, 0,     0);
    queue_request(wuf_pkg::CMD_QUERY,   0,     1023);
    queue_request(wuf_pkg::CMD_CONNECT, 0,     1);
    queue_request(wuf_pkg::CMD_CONNECT, 1,     0);
    queue_request(wuf_pkg::CMD_QUERY,   1,     0);
    queue_request(wuf_pkg::CMD_CONNECT, 1023,  1022);
    queue_request(wuf_pkg::CMD_CONNECT, 1023,  1023);
    queue_request(wuf_pkg::CMD_CONNECT, 2,     1);
    queue_request(wuf_pkg::CMD_CONNECT, 1022,  0);
    queue_request(wuf_pkg::CMD_QUERY,   1022,  2);
    queue_request(wuf_pkg::CMD_QUERY,   1023,  1023);
    queue_request(wuf_pkg::CMD_CONNECT, 'h2AA, 'h155);
    queue_request(wuf_pkg::CMD_QUERY,   'h155, 'h2AA);
    queue_request(wuf_pkg::CMD_CONNECT, 'h155, 1);
    queue_request(wuf_pkg::CMD_CONNECT, 1,     'h155);
    queue_request(wuf_pkg::CMD_CONNECT, 512,   511);
    queue_request(wuf_pkg::CMD_QUERY,   511,   1023);
    queue_request(wuf_pkg::CMD_QUERY,   512,   1);
    queue_request(wuf_pkg::CMD_CONNECT, 1,     512);

    // Balanced build over the upper half. Each level joins neighboring
    // trees of equal size, so the trees gain one level per pass. The argument
    // order is random so that ties resolve both ways.
    drain_next = 1'b1;
    for (int stride = 1; stride < 512; stride = stride * 2) begin
      for (int i = 0; i < 512; i = i + 2 * stride) begin
        int unsigned lo;
        int unsigned hi;
        lo = 512 + i + $urandom_range(0, stride - 1);
        hi = 512 + i + stride + $urandom_range(0, stride - 1);
        if ($urandom_range(0, 1))
          queue_request(wuf_pkg::CMD_CONNECT, lo, hi);
        else
          queue_request(wuf_pkg::CMD_CONNECT, hi, lo);
        if ($urandom_range(0, 99) < 35) queue_noise();
      end
    end

    // Uniform phase. Some pairs are close to each other so that queries
    // inside one tree keep showing up.
    drain_next = 1'b1;
    while (request_total < 1770) begin
      int unsigned a;
      a = $urandom_range(0, 1023);
      if ($urandom_range(0, 99) < 25)
        queue_request(wuf_pkg::wuf_cmd_t'($urandom_range(0, 1)), a,
                      a ^ $urandom_range(0, 15));
      else
        queue_request(wuf_pkg::wuf_cmd_t'($urandom_range(0, 1)), a,
                      $urandom_range(0, 1023));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_total < request_total || outcome_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run, including the clearing
  // pass after reset.
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== weighted_union_find.f =====
+incdir+src
src/wuf_pkg.sv
src/wuf_ram.sv
src/weighted_union_find.sv
verif/testbench.sv
